[rtl/core/open_addressing_hash_insert_unit_assert.svh]
// ----------------------------------------------------------------------------
// open addressing hash insert unit assertion macros
// shared property forms for the unit's concurrent checks
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_INSERT_UNIT_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_INSERT_UNIT_ASSERT_SVH

// same-cycle implication
`define OAHI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OAHI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/oahi_pkg.sv]
// ----------------------------------------------------------------------------
// oahi package
// shared constants, codes and types of the open addressing hash insert unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oahi_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 1024;

   localparam int unsigned KEY_W      = 31;
   localparam int unsigned SLOT_W     = 10;
   localparam int unsigned SIZE_W     = 11;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_DATA_W = 11;
   localparam int unsigned CSR_IDX_W  = 1;

   // remainder unit: two dividend bits retired per cycle
   localparam int unsigned DIVIDEND_W = 32;
   localparam int unsigned DIV_STEPS  = DIVIDEND_W / 2;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd11;

   localparam logic STATUS_STORED = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_SIZE = 1'b0,
      CSR_PROBE_MODE = 1'b1
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR = 2'd0,
      MODE_STEP3  = 2'd1,
      MODE_QUAD   = 2'd2
   } probe_mode_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_CHECK
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/core/oahi_front.sv]
// ----------------------------------------------------------------------------
// oahi front
// accepts a request and reduces its key to the home slot, two bits a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "open_addressing_hash_insert_unit_assert.svh"

module oahi_front
   import oahi_pkg::*;
#(
   parameter int unsigned IW = 10,
   parameter int unsigned MW = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clearing,
   input  logic [MW-1:0]           eff_size,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KEY_W-1:0]        req_key,
   input  queue_status_type        q_status,
   output logic                    push_valid,
   output logic [KEY_W-1:0]        push_key,
   output logic [IW-1:0]           push_home
);

   front_state_type        state_ff, state_in;
   logic [DIVIDEND_W-1:0]  dividend_ff, dividend_in;
   logic [MW-1:0]          rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic                   req_ok;

   // one restoring step: shift in a bit, subtract the size once if reached
   function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] r, input logic b,
                                               input logic [MW-1:0] d);
      logic [MW:0] t;
      begin
         t = {r, b};
         if (t >= {1'b0, d}) t = t - {1'b0, d};
         rem_step = t[MW-1:0];
      end
   endfunction

   assign req_stall = (state_ff != F_IDLE) || clearing;
   assign req_ok    = req_valid && !req_stall;
   assign push_key  = key_ff;
   assign push_home = IW'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      key_ff      <= key_in;
   end

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      key_in      = key_ff;
      push_valid  = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_ok) begin
               dividend_in = {1'b0, req_key};
               key_in      = req_key;
               rem_in      = '0;
               cnt_in      = '0;
               state_in    = F_DIV;
            end
         end
         F_DIV: begin
            rem_in      = rem_step(rem_step(rem_ff, dividend_ff[DIVIDEND_W-1], eff_size),
                                   dividend_ff[DIVIDEND_W-2], eff_size);
            dividend_in = dividend_ff << 2;
            cnt_in      = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (!q_status.full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   `OAHI_ASSERT_IMP(a_rem_bound, clock, reset, state_ff == F_DIV, rem_ff < eff_size, "partial remainder reached table size")
   `OAHI_ASSERT_IMP(a_push_home_bound, clock, reset, push_valid, rem_ff < eff_size, "home slot beyond table size")

endmodule

[rtl/core/oahi_queue.sv]
// ----------------------------------------------------------------------------
// oahi queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oahi_queue
   import oahi_pkg::*;
#(
   parameter int unsigned DATA_W = 41
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  logic [DATA_W-1:0]   push_data,
   input  logic                pop,
   output logic [DATA_W-1:0]   pop_data,
   output queue_status_type    status
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[rtl/core/oahi_back.sv]
// ----------------------------------------------------------------------------
// oahi back
// clears the occupancy store after reset, then walks the probe sequence
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "open_addressing_hash_insert_unit_assert.svh"

module oahi_back
   import oahi_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int unsigned IW          = 10,
   parameter int unsigned MW          = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [MW-1:0]       eff_size,
   input  logic [MODE_W-1:0]   probe_mode,
   input  queue_status_type    q_status,
   input  logic [KEY_W-1:0]    pop_key,
   input  logic [IW-1:0]       pop_home,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_status
);

   logic                used_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]    key_mem  [TABLE_DEPTH];

   back_state_type      state_ff, state_in;
   logic [IW-1:0]       clr_addr_ff, clr_addr_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [IW-1:0]       inc_ff, inc_in;
   logic [IW-1:0]       n_ff, n_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic                used_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                used_wr_en, used_wr_data, key_wr_en;
   logic [IW-1:0]       used_wr_addr;
   logic                commit, commit_status, out_free, last_probe;
   logic [MW-1:0]       step, step3;
   logic [MW:0]         pos_sum, inc_sum;
   logic [IW-1:0]       pos_next, inc_next;

   assign clearing   = (state_ff == B_CLEAR);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_probe = (MW'(n_ff) + MW'(1)) == eff_size;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   // next probe position and quadratic increment, each wrapped by one subtract
   always_comb begin
      if (eff_size == MW'(2))      step3 = MW'(1);
      else if (eff_size == MW'(3)) step3 = '0;
      else                         step3 = MW'(3);
      unique case (probe_mode)
         MODE_STEP3: step = step3;
         MODE_QUAD:  step = MW'(inc_ff);
         default:    step = MW'(1);
      endcase
      pos_sum = {1'b0, MW'(pos_ff)} + {1'b0, step};
      if (pos_sum >= {1'b0, eff_size}) pos_sum = pos_sum - {1'b0, eff_size};
      pos_next = IW'(pos_sum);
      inc_sum = {1'b0, MW'(inc_ff)} + (MW+1)'(2);
      if (inc_sum >= {1'b0, eff_size}) inc_sum = inc_sum - {1'b0, eff_size};
      inc_next = IW'(inc_sum);
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      pos_in        = pos_ff;
      inc_in        = inc_ff;
      n_in          = n_ff;
      key_in        = key_ff;
      used_wr_en    = 1'b0;
      used_wr_addr  = pos_ff;
      used_wr_data  = 1'b1;
      key_wr_en     = 1'b0;
      pop           = 1'b0;
      commit        = 1'b0;
      commit_status = STATUS_STORED;
      unique case (state_ff)
         B_CLEAR: begin
            used_wr_en   = 1'b1;
            used_wr_addr = clr_addr_ff;
            used_wr_data = 1'b0;
            clr_addr_in  = clr_addr_ff + IW'(1);
            if (clr_addr_ff == IW'(TABLE_DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               pos_in   = pop_home;
               key_in   = pop_key;
               inc_in   = IW'(1);
               n_in     = '0;
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if (!used_rd_ff) begin
               if (out_free) begin
                  used_wr_en = 1'b1;
                  key_wr_en  = 1'b1;
                  commit     = 1'b1;
                  state_in   = B_IDLE;
               end
            end else if (last_probe) begin
               if (out_free) begin
                  commit        = 1'b1;
                  commit_status = STATUS_FULL;
                  state_in      = B_IDLE;
               end
            end else begin
               pos_in   = pos_next;
               inc_in   = inc_next;
               n_in     = n_ff + IW'(1);
               state_in = B_READ;
            end
         end
         default: state_in = B_IDLE;
      endcase

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = SLOT_W'(pos_ff);
         rsp_status_in = commit_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      inc_ff        <= inc_in;
      n_ff          <= n_in;
      key_ff        <= key_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // occupancy and key stores, registered read at the current probe
   always_ff @(posedge clock) begin
      if (used_wr_en) used_mem[used_wr_addr] <= used_wr_data;
      if (key_wr_en) key_mem[pos_ff] <= key_ff;
      used_rd_ff <= used_mem[pos_ff];
   end

   `OAHI_ASSERT_IMP(a_commit_in_range, clock, reset, commit, MW'(pos_ff) < eff_size, "committed slot beyond table size")
   `OAHI_ASSERT_IMP(a_full_on_last, clock, reset, commit && (commit_status == STATUS_FULL), last_probe, "full reported before last probe")
   `OAHI_ASSERT_IMP(a_probe_count, clock, reset, state_ff == B_CHECK, MW'(n_ff) < eff_size, "probe count ran past table size")
   `OAHI_ASSERT_NXT(a_commit_shows, clock, reset, commit, rsp_valid_ff, "committed result not presented")

endmodule

[rtl/core/open_addressing_hash_insert_unit.sv]
// path: the front accepts a request, reduces its key and pushes it to the queue;
//   the back pops it and reads and checks the home slot, then each further probe
// flow: the front takes a new request only once the last is pushed to the queue;
//   the two-bit-a-cycle remainder unit sets the pace unless the probe walk is longer
// reset: synchronous; a clearing pass then sweeps every entry of the occupancy store,
//   and requests stall until it ends
// ----------------------------------------------------------------------------
// open addressing hash insert unit
// inserts keys into an open addressing table with linear, step-three or
// quadratic probing and reports the slot or a full table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module open_addressing_hash_insert_unit
   import oahi_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration writes
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KEY_W-1:0]        req_key,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SLOT_W-1:0]       rsp_slot,
   output logic                    rsp_status
);

   // slot index width and width that can hold the table size itself
   localparam int unsigned IW = $clog2(TABLE_DEPTH);
   localparam int unsigned MW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned CW = (MW > SIZE_W) ? MW : SIZE_W;

   logic [SIZE_W-1:0]     table_size_ff, table_size_in;
   logic [MODE_W-1:0]     probe_mode_ff, probe_mode_in;
   logic [CW-1:0]         size_ext, size_clamped;
   logic [MW-1:0]         eff_size;

   logic                  clearing;
   logic                  push_valid, pop;
   logic [KEY_W-1:0]      push_key, pop_key;
   logic [IW-1:0]         push_home, pop_home;
   logic [KEY_W+IW-1:0]   pop_data;
   queue_status_type      q_status;

   // register writes; software must write only while the unit is idle, the block does not enforce it
   always_comb begin
      table_size_in = table_size_ff;
      probe_mode_in = probe_mode_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TABLE_SIZE: table_size_in = csr_write_data[SIZE_W-1:0];
            CSR_PROBE_MODE: probe_mode_in = csr_write_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SIZE_RESET;
         probe_mode_ff <= MODE_LINEAR;
      end else begin
         table_size_ff <= table_size_in;
         probe_mode_ff <= probe_mode_in;
      end
   end

   // sizes below two act as two, sizes beyond the store act as its depth
   always_comb begin
      size_ext = CW'(table_size_ff);
      if (size_ext < CW'(2))                 size_clamped = CW'(2);
      else if (size_ext > CW'(TABLE_DEPTH))  size_clamped = CW'(TABLE_DEPTH);
      else                                   size_clamped = size_ext;
      eff_size = MW'(size_clamped);
   end

   // front: accept and reduce key to its home slot
   oahi_front #(
      .IW (IW),
      .MW (MW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .eff_size   (eff_size),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_key    (req_key),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_key   (push_key),
      .push_home  (push_home)
   );

   // queue of classified requests lets front and back stall apart
   oahi_queue #(
      .DATA_W (KEY_W + IW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_key, push_home}),
      .pop        (pop),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   assign pop_key  = pop_data[KEY_W+IW-1:IW];
   assign pop_home = pop_data[IW-1:0];

   // back: probe walk against the occupancy store, output register
   oahi_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IW          (IW),
      .MW          (MW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .eff_size   (eff_size),
      .probe_mode (probe_mode_ff),
      .q_status   (q_status),
      .pop_key    (pop_key),
      .pop_home   (pop_home),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status)
   );

endmodule
